FILE: design/utrf_pkg.sv
// Shared types, constants and reset values for the UART transceiver with receive FIFO.
`timescale 1ns / 1ps
package utrf_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;

  localparam int unsigned BIT_TIME_W     = 16;
  localparam int unsigned FIRST_SAMPLE_W = 17;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FILL_W         = 6;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 17;
  localparam int unsigned BIT_INDEX_W    = 4;

  localparam logic [BIT_TIME_W-1:0]     BIT_TIME_RST     = 16'd8333;
  localparam logic [FIRST_SAMPLE_W-1:0] FIRST_SAMPLE_RST = 17'd10610;

  // Frame positions: start bit is 0, data bits 1..8, stop bits after.
  localparam logic [BIT_INDEX_W-1:0] DATA_BITS   = 4'd8;
  localparam logic [BIT_INDEX_W-1:0] TX_END_ONE  = 4'd10;
  localparam logic [BIT_INDEX_W-1:0] TX_END_TWO  = 4'd11;
  localparam logic [BIT_INDEX_W-1:0] RX_STOP_TWO = 4'd9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIT_TIME     = 2'd0,
    CFG_FIRST_SAMPLE = 2'd1,
    CFG_TWO_STOP     = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic              rx_level;
    logic              tx_start;
    logic [BYTE_W-1:0] tx_data;
    logic              pop_req;
    logic              flush;
  } in_word_t;

  typedef struct packed {
    logic              tx_level;
    logic              tx_busy;
    logic              head_valid;
    logic [BYTE_W-1:0] head_data;
    logic [FILL_W-1:0] fill_count;
  } out_word_t;

  typedef struct packed {
    logic [BIT_TIME_W-1:0]     bit_time;
    logic [FIRST_SAMPLE_W-1:0] first_sample;
    logic                      two_stop;
  } cfg_regs_t;

  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
  } rx_push_t;

  typedef struct packed {
    logic              head_valid;
    logic [BYTE_W-1:0] head_data;
    logic [FILL_W-1:0] fill_count;
  } fifo_stat_t;

  // A timing register of zero counts as one tick.
  function automatic logic [BIT_TIME_W-1:0] bit_ticks(input logic [BIT_TIME_W-1:0] v);
    bit_ticks = (v == '0) ? BIT_TIME_W'(1) : v;
  endfunction

  function automatic logic [FIRST_SAMPLE_W-1:0] first_ticks(
    input logic [FIRST_SAMPLE_W-1:0] v
  );
    first_ticks = (v == '0) ? FIRST_SAMPLE_W'(1) : v;
  endfunction

endpackage

FILE: design/utrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module utrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/utrf_rx.sv
// Receive engine: start edge detect, bit sampling and stop-time wait.
`timescale 1ns / 1ps
module utrf_rx (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                rx_level,
  input  utrf_pkg::cfg_regs_t cfg,
  output utrf_pkg::rx_push_t  push
);
  import utrf_pkg::*;

  logic                      prev_r, prev_nxt;
  logic                      active_r, active_nxt;
  logic [FIRST_SAMPLE_W-1:0] timer_r, timer_nxt;
  logic [BIT_INDEX_W-1:0]    idx_r, idx_nxt;
  logic [BYTE_W-1:0]         shift_r, shift_nxt;
  logic [FIRST_SAMPLE_W-1:0] timer_dec;
  logic [FIRST_SAMPLE_W-1:0] bit_reload;

  assign timer_dec  = timer_r - 1'b1;
  assign bit_reload = FIRST_SAMPLE_W'(bit_ticks(cfg.bit_time));

  always_comb begin
    prev_nxt   = rx_level;
    active_nxt = active_r;
    timer_nxt  = timer_r;
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    push.push  = 1'b0;
    push.data  = shift_r;
    if (!active_r) begin
      if (prev_r && !rx_level) begin
        active_nxt = 1'b1;
        timer_nxt  = first_ticks(cfg.first_sample);
        idx_nxt    = '0;
        shift_nxt  = '0;
      end
    end else begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (idx_r < DATA_BITS) begin
          shift_nxt = {rx_level, shift_r[BYTE_W-1:1]};
          idx_nxt   = idx_r + 1'b1;
          timer_nxt = bit_reload;
        end else if (idx_r == DATA_BITS && cfg.two_stop) begin
          idx_nxt   = RX_STOP_TWO;
          timer_nxt = bit_reload;
        end else begin
          push.push  = 1'b1;
          active_nxt = 1'b0;
          idx_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b1;
      active_r <= 1'b0;
      timer_r  <= '0;
      idx_r    <= '0;
      shift_r  <= '0;
    end else if (step) begin
      prev_r   <= prev_nxt;
      active_r <= active_nxt;
      timer_r  <= timer_nxt;
      idx_r    <= idx_nxt;
      shift_r  <= shift_nxt;
    end
  end

  a_rx_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= RX_STOP_TWO)
    else $error("rx bit index out of range");

  a_rx_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> idx_r == '0)
    else $error("rx idle with nonzero bit index");

  a_rx_push_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && push.push |=> !active_r)
    else $error("rx still active after delivering a byte");

endmodule

FILE: design/utrf_tx.sv
// Transmit engine: start, data and stop bits, each held for one bit time.
`timescale 1ns / 1ps
module utrf_tx (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         tx_start,
  input  logic [utrf_pkg::BYTE_W-1:0]  tx_data,
  input  utrf_pkg::cfg_regs_t          cfg,
  output logic                         tx_level,
  output logic                         tx_busy
);
  import utrf_pkg::*;

  logic                   active_r, active_nxt;
  logic [BIT_TIME_W-1:0]  timer_r, timer_nxt;
  logic [BIT_INDEX_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0]      shift_r, shift_nxt;
  logic                   run;
  logic [BIT_TIME_W-1:0]  timer_cur, timer_dec;
  logic [BIT_INDEX_W-1:0] idx_cur, idx_inc;
  logic [BYTE_W-1:0]      shift_cur;
  logic                   in_data;

  // A start request on an idle transmitter loads the frame this same tick.
  assign run       = active_r || tx_start;
  assign timer_cur = active_r ? timer_r : bit_ticks(cfg.bit_time);
  assign idx_cur   = active_r ? idx_r : '0;
  assign shift_cur = active_r ? shift_r : tx_data;
  assign timer_dec = timer_cur - 1'b1;
  assign idx_inc   = idx_cur + 1'b1;
  assign in_data   = (idx_cur != '0) && (idx_cur <= DATA_BITS);

  always_comb begin
    tx_busy    = run;
    tx_level   = 1'b1;
    active_nxt = active_r;
    timer_nxt  = timer_r;
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    if (run) begin
      if (idx_cur == '0) begin
        tx_level = 1'b0;
      end else if (in_data) begin
        tx_level = shift_cur[0];
      end
      active_nxt = 1'b1;
      timer_nxt  = timer_dec;
      idx_nxt    = idx_cur;
      shift_nxt  = shift_cur;
      if (timer_dec == '0) begin
        if (in_data) begin
          shift_nxt = shift_cur >> 1;
        end
        if (idx_inc >= (cfg.two_stop ? TX_END_TWO : TX_END_ONE)) begin
          active_nxt = 1'b0;
          idx_nxt    = '0;
        end else begin
          idx_nxt   = idx_inc;
          timer_nxt = bit_ticks(cfg.bit_time);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      timer_r  <= '0;
      idx_r    <= '0;
      shift_r  <= '0;
    end else if (step) begin
      active_r <= active_nxt;
      timer_r  <= timer_nxt;
      idx_r    <= idx_nxt;
      shift_r  <= shift_nxt;
    end
  end

  a_tx_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < TX_END_TWO)
    else $error("tx bit index out of range");

  a_tx_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> idx_r == '0)
    else $error("tx idle with nonzero bit index");

  a_tx_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> timer_r != '0)
    else $error("tx active with expired timer");

endmodule

FILE: design/utrf_fifo.sv
// Receive ring FIFO: pointers, fill count and registered head read.
`timescale 1ns / 1ps
module utrf_fifo #(
  parameter int unsigned FIFO_DEPTH = utrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 pop_req,
  input  logic                 flush,
  input  utrf_pkg::rx_push_t   push,
  output utrf_pkg::fifo_stat_t stat
);
  import utrf_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              valid_r;
  logic [FILL_W-1:0] fill_r;
  logic              byp_r;
  logic [BYTE_W-1:0] byp_data_r;
  logic [PTR_W-1:0]  rd_after_pop, wr_inc;
  logic              do_write;
  logic [CNT_W-1:0]  fill_nxt;
  logic [BYTE_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Pop sees the FIFO as it stood before this tick, then the write, then flush.
  assign rd_after_pop = (pop_req && wr_ptr_r != rd_ptr_r) ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  assign wr_inc       = ptr_inc(wr_ptr_r);
  assign do_write     = push.push && (wr_inc != rd_after_pop);
  assign wr_ptr_nxt   = flush ? '0 : (do_write ? wr_inc : wr_ptr_r);
  assign rd_ptr_nxt   = flush ? '0 : rd_after_pop;
  assign fill_nxt     = (wr_ptr_nxt >= rd_ptr_nxt)
                        ? {1'b0, wr_ptr_nxt} - {1'b0, rd_ptr_nxt}
                        : {1'b0, wr_ptr_nxt} + DEPTH_CNT - {1'b0, rd_ptr_nxt};

  utrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (step && do_write),
    .wr_addr (wr_ptr_r),
    .wr_data (push.data),
    .rd_en   (step),
    .rd_addr (rd_ptr_nxt),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      valid_r  <= 1'b0;
      fill_r   <= '0;
      byp_r    <= 1'b0;
    end else if (step) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      valid_r  <= wr_ptr_nxt != rd_ptr_nxt;
      fill_r   <= FILL_W'(fill_nxt);
      // The RAM reads old contents while the same entry is written: forward.
      byp_r    <= do_write && (wr_ptr_r == rd_ptr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byp_data_r <= push.data;
    end
  end

  assign stat.head_valid = valid_r;
  assign stat.head_data  = valid_r ? (byp_r ? byp_data_r : ram_rdata) : '0;
  assign stat.fill_count = fill_r;

  a_fifo_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= PTR_LAST && rd_ptr_r <= PTR_LAST)
    else $error("fifo pointer beyond depth");

  a_fifo_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    step && flush |=> !valid_r && fill_r == '0)
    else $error("fifo not empty after flush");

  a_fifo_valid_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r == (wr_ptr_r != rd_ptr_r))
    else $error("fifo head valid disagrees with pointers");

endmodule

FILE: design/uart_transceiver_rx_fifo_core.sv
// Top level: full-duplex UART transceiver with receive ring FIFO.
`timescale 1ns / 1ps
// Every input word is one tick of the line time base; every word accepted
// yields exactly one result word describing that tick. The block takes one
// word per clock while the output register is free or draining: a word is
// held in the input register, then the receiver, transmitter and FIFO
// pointers advance together and the result lands in the output register
// (and the FIFO RAM's registered read port). The input register refills
// in the same cycle the output register is taken, so the rate is set only
// by the sink: with out_ready held high, one result per
// clock. The receiver starts a frame on a falling edge while idle, samples
// eight bits LSB first at first_sample and then every bit_time ticks, waits
// one or two stop times (two_stop) without checking the line, and pushes the
// byte, dropping it when the FIFO is full. The FIFO holds FIFO_DEPTH - 1
// bytes; within one tick pop acts first, then the received byte is written,
// then flush clears everything. The transmitter starts on tx_start only
// while idle and sends start, eight data bits and one or two stop bits.
// tx_level and tx_busy describe the line during the tick; head_valid,
// head_data (zero when empty) and fill_count (low six bits) show the FIFO
// after the tick. Configuration words (index 0 bit_time, 1 first_sample,
// 2 two_stop; other indexes ignored) are always taken and should be written
// only while no word is in flight. A zero timing value counts as one tick.
// The FIFO RAM contents are not cleared at reset; no entry is ever shown
// before it is written, so no clearing pass is needed.
module uart_transceiver_rx_fifo_core #(
  parameter int unsigned FIFO_DEPTH = utrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  utrf_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output utrf_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [utrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [utrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import utrf_pkg::*;

  logic       in_valid_r;
  in_word_t   in_word_r;
  logic       out_valid_r;
  logic       tx_level_r;
  logic       tx_busy_r;
  logic       step;
  cfg_regs_t  cfg_r;
  rx_push_t   rx_push;
  fifo_stat_t fifo_stat;
  logic       tx_level;
  logic       tx_busy;

  // Advance the held word whenever the output register is free or draining.
  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tx_level_r  <= 1'b1;
      tx_busy_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        tx_level_r  <= tx_level;
        tx_busy_r   <= tx_busy;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_time     <= BIT_TIME_RST;
      cfg_r.first_sample <= FIRST_SAMPLE_RST;
      cfg_r.two_stop     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIT_TIME:     cfg_r.bit_time     <= cfg_data[BIT_TIME_W-1:0];
        CFG_FIRST_SAMPLE: cfg_r.first_sample <= cfg_data[FIRST_SAMPLE_W-1:0];
        CFG_TWO_STOP:     cfg_r.two_stop     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  utrf_rx u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_level (in_word_r.rx_level),
    .cfg      (cfg_r),
    .push     (rx_push)
  );

  utrf_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .tx_start (in_word_r.tx_start),
    .tx_data  (in_word_r.tx_data),
    .cfg      (cfg_r),
    .tx_level (tx_level),
    .tx_busy  (tx_busy)
  );

  utrf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pop_req (in_word_r.pop_req),
    .flush   (in_word_r.flush),
    .push    (rx_push),
    .stat    (fifo_stat)
  );

  assign out_valid           = out_valid_r;
  assign out_data.tx_level   = tx_level_r;
  assign out_data.tx_busy    = tx_busy_r;
  assign out_data.head_valid = fifo_stat.head_valid;
  assign out_data.head_data  = fifo_stat.head_data;
  assign out_data.fill_count = fifo_stat.fill_count;

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !tx_busy_r |-> tx_level_r)
    else $error("transmit line low while transmitter idle");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("advanced word produced no result");

  a_head_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fifo_stat.head_valid |-> fifo_stat.fill_count != '0 || FIFO_DEPTH > 64)
    else $error("head valid with zero fill count");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !fifo_stat.head_valid |-> fifo_stat.head_data == '0)
    else $error("head data nonzero on empty fifo");

endmodule

FILE: bench/utrf_status_checker.sv
// Checker that predicts the per-tick transceiver status and compares it with the result channel.
`timescale 1ns / 1ps
module utrf_status_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  utrf_pkg::in_word_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  utrf_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [utrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [utrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      fail_count,
  output int unsigned                      pending,
  output int unsigned                      checked_count,
  output int unsigned                      bytes_stored,
  output int unsigned                      bytes_dropped
);
  import utrf_pkg::*;

  localparam int unsigned DEPTH        = FIFO_DEPTH_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  // Register copies
  logic [BIT_TIME_W-1:0]     bit_time_r;
  logic [FIRST_SAMPLE_W-1:0] first_sample_r;
  logic                      two_stop_r;

  // Receiver
  logic                      rx_prev;
  logic                      rx_busy;
  logic [FIRST_SAMPLE_W-1:0] rx_count;
  logic [BIT_INDEX_W-1:0]    rx_pos;
  logic [BYTE_W-1:0]         rx_byte;

  // Transmitter
  logic                      tx_busy_r;
  logic [BIT_TIME_W-1:0]     tx_count;
  logic [BIT_INDEX_W-1:0]    tx_pos;
  logic [BYTE_W-1:0]         tx_byte;

  // Receive ring
  logic [BYTE_W-1:0]         ring [DEPTH];
  logic [FILL_W-1:0]         wr_ptr;
  logic [FILL_W-1:0]         rd_ptr;

  out_word_t                 status_due [$];
  int unsigned               fails;
  int unsigned               checked;
  int unsigned               stored;
  int unsigned               dropped;

  function automatic logic [FIRST_SAMPLE_W-1:0] nonzero_ticks(
    input logic [FIRST_SAMPLE_W-1:0] v
  );
    return (v == '0) ? FIRST_SAMPLE_W'(1) : v;
  endfunction

  // Advance one tick of the line: pop, receive, flush, then transmit.
  task automatic tick_uart(input in_word_t w, output out_word_t s);
    logic [FILL_W-1:0] next_wr;
    logic [FILL_W-1:0] fill;
    if (w.pop_req && wr_ptr != rd_ptr) begin
      rd_ptr = rd_ptr + 1'b1;
    end

    if (!rx_busy) begin
      if (rx_prev && !w.rx_level) begin
        rx_busy  = 1'b1;
        rx_count = nonzero_ticks(first_sample_r);
        rx_pos   = '0;
        rx_byte  = '0;
      end
    end else begin
      rx_count = rx_count - 1'b1;
      if (rx_count == '0) begin
        if (rx_pos < DATA_BITS) begin
          rx_byte  = {w.rx_level, rx_byte[BYTE_W-1:1]};
          rx_pos   = rx_pos + 1'b1;
          rx_count = nonzero_ticks(FIRST_SAMPLE_W'(bit_time_r));
        end else if (rx_pos == DATA_BITS && two_stop_r) begin
          rx_pos   = RX_STOP_TWO;
          rx_count = nonzero_ticks(FIRST_SAMPLE_W'(bit_time_r));
        end else begin
          next_wr = wr_ptr + 1'b1;
          if (next_wr != rd_ptr) begin
            ring[wr_ptr] = rx_byte;
            wr_ptr = next_wr;
            stored++;
          end else begin
            dropped++;
          end
          rx_busy = 1'b0;
          rx_pos  = '0;
        end
      end
    end
    rx_prev = w.rx_level;

    if (w.flush) begin
      wr_ptr = '0;
      rd_ptr = '0;
    end

    if (!tx_busy_r && w.tx_start) begin
      tx_busy_r = 1'b1;
      tx_byte   = w.tx_data;
      tx_pos    = '0;
      tx_count  = BIT_TIME_W'(nonzero_ticks(FIRST_SAMPLE_W'(bit_time_r)));
    end
    if (!tx_busy_r) begin
      s.tx_level = 1'b1;
      s.tx_busy  = 1'b0;
    end else begin
      s.tx_busy = 1'b1;
      if (tx_pos == '0) begin
        s.tx_level = 1'b0;
      end else if (tx_pos <= DATA_BITS) begin
        s.tx_level = tx_byte[0];
      end else begin
        s.tx_level = 1'b1;
      end
      tx_count = tx_count - 1'b1;
      if (tx_count == '0) begin
        if (tx_pos >= 1 && tx_pos <= DATA_BITS) begin
          tx_byte = tx_byte >> 1;
        end
        tx_pos = tx_pos + 1'b1;
        if (tx_pos >= (two_stop_r ? TX_END_TWO : TX_END_ONE)) begin
          tx_busy_r = 1'b0;
          tx_pos    = '0;
        end else begin
          tx_count = BIT_TIME_W'(nonzero_ticks(FIRST_SAMPLE_W'(bit_time_r)));
        end
      end
    end

    fill         = wr_ptr - rd_ptr;
    s.head_valid = (fill != '0);
    s.head_data  = (fill != '0) ? ring[rd_ptr] : '0;
    s.fill_count = fill;
  endtask

  always @(posedge clk) begin : track
    out_word_t want;
    logic      bad;
    if (!rst_n) begin
      bit_time_r     = BIT_TIME_RST;
      first_sample_r = FIRST_SAMPLE_RST;
      two_stop_r     = 1'b0;
      rx_prev        = 1'b1;
      rx_busy        = 1'b0;
      rx_count       = '0;
      rx_pos         = '0;
      rx_byte        = '0;
      tx_busy_r      = 1'b0;
      tx_count       = '0;
      tx_pos         = '0;
      tx_byte        = '0;
      wr_ptr         = '0;
      rd_ptr         = '0;
      for (int i = 0; i < DEPTH; i++) begin
        ring[i] = '0;
      end
      status_due.delete();
      fails   = 0;
      checked = 0;
      stored  = 0;
      dropped = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_BIT_TIME:     bit_time_r     = cfg_data[BIT_TIME_W-1:0];
          CFG_FIRST_SAMPLE: first_sample_r = cfg_data[FIRST_SAMPLE_W-1:0];
          CFG_TWO_STOP:     two_stop_r     = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tick_uart(in_data, want);
        status_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        checked++;
        if (status_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("status word %0d arrived with nothing due: %p", checked, out_data);
          end
        end else begin
          want = status_due.pop_front();
          bad  = (out_data.tx_level   !== want.tx_level)   ||
                 (out_data.tx_busy    !== want.tx_busy)    ||
                 (out_data.head_valid !== want.head_valid) ||
                 (out_data.head_data  !== want.head_data)  ||
                 (out_data.fill_count !== want.fill_count);
          if (bad) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("status word %0d: want lvl=%b busy=%b head=%b/%h fill=%0d",
                       checked, want.tx_level, want.tx_busy, want.head_valid,
                       want.head_data, want.fill_count);
              $display("                 got  lvl=%b busy=%b head=%b/%h fill=%0d",
                       out_data.tx_level, out_data.tx_busy, out_data.head_valid,
                       out_data.head_data, out_data.fill_count);
            end
          end
        end
      end
    end
    fail_count    <= fails;
    pending       <= status_due.size();
    checked_count <= checked;
    bytes_stored  <= stored;
    bytes_dropped <= dropped;
  end

endmodule

FILE: bench/uart_transceiver_rx_fifo_core_tb.sv
// Testbench top: line-tick stimulus, idling and verdict for the UART transceiver with receive FIFO.
`timescale 1ns / 1ps
module uart_transceiver_rx_fifo_core_tb;
  import utrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 250_000;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_SLACK     = 8;

  // How the two sides idle during a stretch of stimulus
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked_count;
  int unsigned bytes_stored;
  int unsigned bytes_dropped;

  // Receive line waveform, one level per tick, consumed front first
  bit          rx_line [$];
  int unsigned line_bt;
  int unsigned stop_ticks;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_off_reqs;
  int unsigned hold_offs_done;
  int unsigned ticks_sent;
  int unsigned settings_run;
  int unsigned cycle_count;

  uart_transceiver_rx_fifo_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  utrf_status_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .bytes_stored  (bytes_stored),
    .bytes_dropped (bytes_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: the run must finish well inside this many cycles.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: stall at the current rate, or hold off completely for a long
  // stretch on request so the block backs up and drops in_ready.
  initial begin
    out_ready <= 1'b0;
    hold_offs_done = 0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != hold_offs_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Next receive-line level; an empty waveform means an idle (high) line.
  function automatic bit next_rx_level();
    if (rx_line.size() == 0) begin
      return 1'b1;
    end
    return rx_line.pop_front();
  endfunction

  // Append one frame at the current bit time: start, eight bits LSB first, stop.
  task automatic queue_frame(input logic [BYTE_W-1:0] value, input bit stop_level);
    repeat (line_bt) rx_line.push_back(1'b0);
    for (int i = 0; i < BYTE_W; i++) begin
      repeat (line_bt) rx_line.push_back(value[i]);
    end
    repeat (stop_ticks) rx_line.push_back(stop_level);
  endtask

  // Offer one word, idling first at the current rate; return once it is taken.
  // Valid stays high between back-to-back words.
  task automatic send_tick(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and wait until every status word due has come back. Every word
  // yields a result, so an empty expectation list means the block is idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Hold the register word until it is taken; the caller lowers valid.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drain, then write all three registers and pick the idling pattern.
  task automatic apply_settings(input logic [BIT_TIME_W-1:0] bt,
                                input logic [FIRST_SAMPLE_W-1:0] fs,
                                input logic two, input idle_mode_t mode);
    wait_drained();
    write_reg(CFG_BIT_TIME, CFG_DATA_W'(bt));
    write_reg(CFG_FIRST_SAMPLE, CFG_DATA_W'(fs));
    write_reg(CFG_TWO_STOP, CFG_DATA_W'(two));
    cfg_valid <= 1'b0;
    line_bt    = (bt == '0) ? 1 : int'(bt);
    stop_ticks = two ? 2 * line_bt : line_bt;
    rx_line.delete();
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        sink_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 48;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        send_idle_pct  = 0;
        sink_stall_pct = 48;
      end
      default: begin
        send_idle_pct  = 7;
        sink_stall_pct = 7;
      end
    endcase
    settings_run++;
  endtask

  // Random ticks. The receive line carries mostly clean frames with random
  // bytes at the configured bit time; the rest is short bursts of random
  // levels or frames cut short, each followed by a long idle so the receiver
  // can fall back into step.
  task automatic run_random(input int unsigned items, input int unsigned frame_pct,
                            input int unsigned pop_pct, input int unsigned flush_pct,
                            input int unsigned tx_pct, input bit line_live);
    in_word_t    w;
    int unsigned pick;
    int unsigned cut;
    repeat (items) begin
      if (line_live && rx_line.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < frame_pct) begin
          // an occasional low stop bit is never checked by the receiver
          queue_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 19) != 0);
          repeat ($urandom_range(0, 2)) rx_line.push_back(1'b1);
        end else if (pick < frame_pct + (100 - frame_pct) / 2) begin
          repeat ($urandom_range(1, 2 * line_bt)) rx_line.push_back(1'($urandom_range(0, 1)));
          repeat (12 * line_bt) rx_line.push_back(1'b1);
        end else begin
          queue_frame(BYTE_W'($urandom_range(0, 255)), 1'b1);
          cut = $urandom_range(1, rx_line.size());
          while (rx_line.size() > cut) void'(rx_line.pop_back());
          repeat (12 * line_bt) rx_line.push_back(1'b1);
        end
      end
      w.rx_level = line_live ? next_rx_level() : 1'b1;
      w.tx_start = ($urandom_range(0, 99) < tx_pct);
      w.tx_data  = BYTE_W'($urandom_range(0, 255));
      w.pop_req  = ($urandom_range(0, 99) < pop_pct);
      w.flush    = ($urandom_range(0, 99) < flush_pct);
      send_tick(w);
    end
  endtask

  initial begin
    logic [BIT_TIME_W-1:0]     bt_pick;
    logic [FIRST_SAMPLE_W-1:0] fs_pick;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_off_reqs  = 0;
    ticks_sent     = 0;
    settings_run   = 0;
    line_bt        = 1;
    stop_ticks     = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Largest timing values with a quiet line and no transmit, so nothing is
    // left running with huge timers; pop and flush on an empty FIFO.
    apply_settings('1, '1, 1'b1, IDLE_NONE);
    run_random(16, 0, 50, 20, 0, 1'b0);

    // Directed ticks at one tick per bit.
    apply_settings(BIT_TIME_W'(1), FIRST_SAMPLE_W'(1), 1'b0, IDLE_BOTH);
    send_tick(in_word_t'{rx_level: 1'b1, tx_start: 1'b0, tx_data: 8'h00,
                         pop_req: 1'b1, flush: 1'b1});
    send_tick(in_word_t'{rx_level: 1'b1, tx_start: 1'b1, tx_data: 8'hFF,
                         pop_req: 1'b0, flush: 1'b0});
    // Two frames back to back, the second with a low stop bit; keep asking to
    // transmit so requests while busy are ignored and a new frame starts on
    // the tick after one ends.
    queue_frame(8'hA5, 1'b1);
    queue_frame(8'h5A, 1'b0);
    while (rx_line.size() != 0) begin
      send_tick(in_word_t'{rx_level: next_rx_level(), tx_start: 1'b1, tx_data: 8'h00,
                           pop_req: 1'b0, flush: 1'b0});
    end
    send_tick(in_word_t'{rx_level: 1'b1, tx_start: 1'b0, tx_data: 8'h3C,
                         pop_req: 1'b1, flush: 1'b0});
    // pop and flush on the same tick with a byte still held
    send_tick(in_word_t'{rx_level: 1'b1, tx_start: 1'b0, tx_data: 8'hC3,
                         pop_req: 1'b1, flush: 1'b1});

    // Zero timing registers behave as one tick.
    apply_settings('0, '0, 1'b1, IDLE_SENDER);
    run_random(150, 85, 30, 2, 30, 1'b1);

    // Fill the FIFO past full with no pops; the sink holds off for a long
    // stretch at the start while words keep coming, so the block backs up.
    apply_settings(BIT_TIME_W'(1), FIRST_SAMPLE_W'(1), 1'b0, IDLE_NONE);
    hold_off_reqs++;
    run_random(800, 95, 0, 0, 20, 1'b1);

    // Random bit times with first samples anywhere up to two bit times; the
    // first of these drains the full FIFO with frequent pops.
    for (int p = 0; p < 4; p++) begin
      bt_pick = BIT_TIME_W'($urandom_range(2, 12));
      fs_pick = FIRST_SAMPLE_W'($urandom_range(1, 2 * int'(bt_pick)));
      apply_settings(bt_pick, fs_pick, 1'($urandom_range(0, 1)), idle_mode_t'((p + 2) % 4));
      run_random((p == 0) ? 150 : 110, 85, (p == 0) ? 70 : 30, 2, 30, 1'b1);
    end

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Ran %0d line ticks over %0d timing settings (zero, one, largest, random);",
             ticks_sent, settings_run);
    $display("%0d status words checked, %0d bytes received, %0d dropped on a full FIFO.",
             checked_count, bytes_stored, bytes_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/utrf_pkg.sv
design/utrf_ram.sv
design/utrf_rx.sv
design/utrf_tx.sv
design/utrf_fifo.sv
design/uart_transceiver_rx_fifo_core.sv
bench/utrf_status_checker.sv
bench/uart_transceiver_rx_fifo_core_tb.sv
